FILE: sv/ftrt_pkg.sv
// Shared types and constants for the five-tuple flow rule table.
// Used by the channel interfaces, the hash unit and the core.
// No dependencies.
package ftrt_pkg;

   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int PROTO_W   = 8;
   localparam int BUCKET_W  = 10;

   // hash key: dst, src, dst port, src port, protocol, most significant first
   localparam int KEY_W       = 2 * ADDR_W + 2 * PORT_W + PROTO_W;
   localparam int CHUNK_W     = 16;
   localparam int CHUNK_COUNT = (KEY_W + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_KEY_W   = CHUNK_COUNT * CHUNK_W;
   localparam int CHUNK_CNT_W = $clog2(CHUNK_COUNT);

   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;
   localparam logic VERDICT_PASS = 1'b1;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_ACCESS,
      ST_REPLY
   } state_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [ADDR_W-1:0]   src_address;
      logic [ADDR_W-1:0]   dst_address;
      logic [PORT_W-1:0]   src_l4_port;
      logic [PORT_W-1:0]   dst_l4_port;
      logic [PROTO_W-1:0]  protocol;
      logic                rule_action;
   } req_word_type;

   typedef struct packed {
      logic                verdict;
      logic                matched;
      logic [BUCKET_W-1:0] bucket;
   } rsp_word_type;

   typedef struct packed {
      logic                valid;
      logic [ADDR_W-1:0]   src_address;
      logic [ADDR_W-1:0]   dst_address;
      logic [PORT_W-1:0]   src_l4_port;
      logic [PORT_W-1:0]   dst_l4_port;
      logic [PROTO_W-1:0]  protocol;
      logic                rule_action;
   } entry_type;

endpackage

FILE: sv/ftrt_if.sv
// Valid/ready channel interfaces for the flow rule table request and
// response words. Depends on ftrt_pkg.
interface ftrt_req_if import ftrt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ftrt_rsp_if import ftrt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/five_tuple_flow_rule_table_core.sv
// Five-tuple exact-match flow rule table, one rule per hash bucket.
// Each request passes the states hash (16-bit key chunks folded in one by one),
// memory access, reply and idle; a new request is taken only in idle, so a
// request's reply is handed on before the next word is accepted.
// Reset: a clearing pass writes every entry invalid; req ready stays low until
// it ends. Depends on ftrt_pkg, ftrt_if, ftrt_hash.
module five_tuple_flow_rule_table_core import ftrt_pkg::*; #(
   parameter int TABLE_DEPTH = 1021
) (
   input  logic       clock,
   input  logic       reset,
   ftrt_req_if.sink   req_chan,
   ftrt_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   state_type    state_ff, state_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   req_word_type item_ff, item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   entry_type    rule_mem [TABLE_DEPTH];
   entry_type    rd_ff;
   logic         mem_we;
   logic         mem_re;
   logic [IDX_W-1:0] mem_waddr;
   entry_type    mem_wdata;

   logic         accept;
   logic         out_free;
   logic         hit;
   logic         hash_start;
   logic         hash_done;
   logic [IDX_W-1:0] hash_idx;
   logic [KEY_W-1:0] hash_key;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // lookups on protocols other than TCP and UDP ignore the ports
   always_comb begin
      item_in = req_chan.data;
      if (req_chan.data.opcode == OP_LOOKUP && req_chan.data.protocol != PROTO_TCP &&
          req_chan.data.protocol != PROTO_UDP) begin
         item_in.src_l4_port = '0;
         item_in.dst_l4_port = '0;
      end
   end

   assign hash_start = accept;
   assign hash_key   = {item_in.dst_address, item_in.src_address, item_in.dst_l4_port,
                        item_in.src_l4_port, item_in.protocol};

   ftrt_hash #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (hash_start),
      .key        (hash_key),
      .done       (hash_done),
      .bucket_idx (hash_idx)
   );

   assign hit = rd_ff.valid &&
                rd_ff.src_address == item_ff.src_address &&
                rd_ff.dst_address == item_ff.dst_address &&
                rd_ff.src_l4_port == item_ff.src_l4_port &&
                rd_ff.dst_l4_port == item_ff.dst_l4_port &&
                rd_ff.protocol == item_ff.protocol;

   always_comb begin
      rsp_word_in.bucket = BUCKET_W'(hash_idx);
      if (item_ff.opcode == OP_INSERT) begin
         rsp_word_in.verdict = item_ff.rule_action;
         rsp_word_in.matched = 1'b0;
      end else begin
         rsp_word_in.verdict = hit ? rd_ff.rule_action : VERDICT_PASS;
         rsp_word_in.matched = hit;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = hash_idx;
      mem_wdata    = {1'b1, item_ff.src_address, item_ff.dst_address, item_ff.src_l4_port,
                      item_ff.dst_l4_port, item_ff.protocol, item_ff.rule_action};
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            mem_we   = (item_ff.opcode == OP_INSERT);
            mem_re   = (item_ff.opcode == OP_LOOKUP);
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (state_ff == ST_REPLY && out_free) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rule_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= rule_mem[hash_idx];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

endmodule

FILE: sv/ftrt_hash.sv
// Bucket hash: key mod TABLE_DEPTH, one CHUNK_W-bit key chunk folded in at a
// time by reciprocal multiplication. Depends on ftrt_pkg.
module ftrt_hash import ftrt_pkg::*; #(
   parameter int TABLE_DEPTH = 1021,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [IDX_W-1:0] bucket_idx
);

   localparam int XW     = IDX_W + CHUNK_W;
   localparam int PROD_W = XW + CHUNK_W + 1;
   localparam longint unsigned RECIP_L = (64'd1 << XW) / 64'(TABLE_DEPTH);
   localparam logic [CHUNK_W:0] RECIP = (CHUNK_W + 1)'(RECIP_L);
   localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

   logic [PAD_KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]       h_ff, h_in;
   logic [IDX_W:0]         x_lo_ff, x_lo_in;
   logic [IDX_W:0]         q_ff, q_in;
   logic [CHUNK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   fold_ff, fold_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [XW-1:0]          x_cur;
   logic [PROD_W-1:0]      prod;
   logic [IDX_W:0]         rem;

   // x = h * 2^CHUNK_W + next chunk; RECIP = floor(2^XW / D) underestimates
   // x / D by less than one, so x - q*D lies in [0, 2D)
   assign x_cur = {h_ff, key_ff[PAD_KEY_W-1 -: CHUNK_W]};
   assign prod  = PROD_W'(x_cur) * PROD_W'(RECIP);

   // the difference is below 2D, so the low bits carry it exactly
   always_comb begin
      rem = x_lo_ff - q_ff * DEPTH_C;
      if (rem >= DEPTH_C) begin
         rem = rem - DEPTH_C;
      end
   end

   always_comb begin
      key_in  = key_ff;
      h_in    = h_ff;
      x_lo_in = x_lo_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      fold_in = fold_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         key_in  = {{(PAD_KEY_W - KEY_W){1'b0}}, key};
         h_in    = '0;
         cnt_in  = '0;
         fold_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff && !fold_ff) begin
         key_in  = key_ff << CHUNK_W;
         x_lo_in = x_cur[IDX_W:0];
         q_in    = (IDX_W + 1)'(prod >> XW);
         fold_in = 1'b1;
      end else if (busy_ff) begin
         h_in    = rem[IDX_W-1:0];
         fold_in = 1'b0;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CHUNK_CNT_W'(CHUNK_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         fold_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         fold_ff <= fold_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      h_ff    <= h_in;
      x_lo_ff <= x_lo_in;
      q_ff    <= q_in;
   end

   assign done       = done_ff;
   assign bucket_idx = h_ff;

endmodule

FILE: sv/ftrt_checker.sv
// Port-level checks for the flow rule table core, bound to the top level.
// Depends on ftrt_pkg and five_tuple_flow_rule_table_core.
module ftrt_checker import ftrt_pkg::*; #(
   parameter int TABLE_DEPTH = 1021
) (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   logic [1:0] pend_ff, pend_in;

   // words accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready)
      else $error("request taken with a result in work and one waiting");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TABLE_DEPTH > 1024) || (int'(rsp_word.bucket) < TABLE_DEPTH))
      else $error("bucket index beyond table depth");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request ready during clearing pass");

endmodule

bind five_tuple_flow_rule_table_core ftrt_checker #(
   .TABLE_DEPTH(TABLE_DEPTH)
) u_ftrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.data)
);

FILE: verif/tb_five_tuple_flow_rule_table_core.sv
`timescale 1ns / 1ps
// Testbench for five_tuple_flow_rule_table_core: directed and random rule inserts and
// packet lookups, checked word by word against a built-in table predictor.
// Depends on ftrt_pkg, ftrt_if and the core RTL.
module tb_five_tuple_flow_rule_table_core;
   import ftrt_pkg::*;

   localparam int TABLE_DEPTH = 1021;
   localparam longint unsigned DEPTH_U = longint'(TABLE_DEPTH);
   localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 64;
   localparam int POOL_MAX = 128;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_word_type req_word = '0;
   logic rsp_ready = 1'b0;
   bit calm = 1'b0;

   ftrt_req_if req_chan ();
   ftrt_rsp_if rsp_chan ();

   assign req_chan.valid = req_valid;
   assign req_chan.data = req_word;
   assign rsp_chan.ready = rsp_ready;

   five_tuple_flow_rule_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   entry_type rule_table [TABLE_DEPTH];
   rsp_word_type expected_rsp_q [$];
   req_word_type rule_pool [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= calm || ($urandom_range(0, 99) >= 16);
   end

   // ---------------- predictor ----------------

   function automatic int unsigned flow_index(input req_word_type k);
      longint unsigned h;
      h = longint'(k.dst_address) % DEPTH_U;
      h = ((h << 32) + longint'(k.src_address)) % DEPTH_U;
      h = ((h << 16) + longint'(k.dst_l4_port)) % DEPTH_U;
      h = ((h << 16) + longint'(k.src_l4_port)) % DEPTH_U;
      h = ((h << 8) + longint'(k.protocol)) % DEPTH_U;
      return int'(h);
   endfunction

   function automatic bit has_ports(input logic [PROTO_W-1:0] proto);
      return proto == PROTO_TCP || proto == PROTO_UDP;
   endfunction

   function automatic rsp_word_type classify_word(input req_word_type w);
      req_word_type k;
      int unsigned idx;
      rsp_word_type r;
      k = w;
      if (k.opcode == OP_LOOKUP && !has_ports(k.protocol)) begin
         k.src_l4_port = '0;
         k.dst_l4_port = '0;
      end
      idx = flow_index(k);
      r.bucket = idx[BUCKET_W-1:0];
      r.matched = 1'b0;
      if (k.opcode == OP_INSERT) begin
         rule_table[idx].valid = 1'b1;
         rule_table[idx].src_address = k.src_address;
         rule_table[idx].dst_address = k.dst_address;
         rule_table[idx].src_l4_port = k.src_l4_port;
         rule_table[idx].dst_l4_port = k.dst_l4_port;
         rule_table[idx].protocol = k.protocol;
         rule_table[idx].rule_action = k.rule_action;
         r.verdict = k.rule_action;
      end else begin
         r.verdict = VERDICT_PASS;
         if (rule_table[idx].valid &&
             rule_table[idx].src_address == k.src_address &&
             rule_table[idx].dst_address == k.dst_address &&
             rule_table[idx].src_l4_port == k.src_l4_port &&
             rule_table[idx].dst_l4_port == k.dst_l4_port &&
             rule_table[idx].protocol == k.protocol) begin
            r.verdict = rule_table[idx].rule_action;
            r.matched = 1'b1;
         end
      end
      return r;
   endfunction

   // ---------------- checker ----------------

   task automatic note_mismatch(input string what, input rsp_word_type want,
                                input rsp_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"mismatch %0d (%s): expected verdict=%0d matched=%0d bucket=%0d,",
                   " got verdict=%0d matched=%0d bucket=%0d"},
                  mismatch_count, what, want.verdict, want.matched, want.bucket,
                  got.verdict, got.matched, got.bucket);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_chan.valid && rsp_ready) begin
         got = rsp_chan.data;
         if (expected_rsp_q.size() == 0) begin
            note_mismatch("no word expected", '0, got);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.verdict !== want.verdict || got.matched !== want.matched ||
                got.bucket !== want.bucket)
               note_mismatch("field differs", want, got);
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic req_word_type make_word(input opcode_type op,
                                              input logic [ADDR_W-1:0] src,
                                              input logic [ADDR_W-1:0] dst,
                                              input logic [PORT_W-1:0] sport,
                                              input logic [PORT_W-1:0] dport,
                                              input logic [PROTO_W-1:0] proto,
                                              input logic act);
      req_word_type w;
      w.opcode = op;
      w.src_address = src;
      w.dst_address = dst;
      w.src_l4_port = sport;
      w.dst_l4_port = dport;
      w.protocol = proto;
      w.rule_action = act;
      return w;
   endfunction

   function automatic req_word_type as_lookup(input req_word_type w);
      req_word_type k;
      k = w;
      k.opcode = OP_LOOKUP;
      k.rule_action = 1'($urandom_range(0, 1));
      return k;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_address();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [PORT_W-1:0] rand_port();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PORT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [PROTO_W-1:0] rand_protocol();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) return PROTO_TCP;
      if (sel < 60) return PROTO_UDP;
      if (sel < 67) return 8'h00;
      if (sel < 74) return 8'hFF;
      if (sel < 80) return PROTO_ICMP;
      return PROTO_W'($urandom_range(0, 255));
   endfunction

   function automatic req_word_type random_key(input opcode_type op);
      req_word_type w;
      w = make_word(op, rand_address(), rand_address(), rand_port(), rand_port(),
                    rand_protocol(), 1'($urandom_range(0, 1)));
      // portless rules mostly stored with zero ports so lookups can hit them
      if (op == OP_INSERT && !has_ports(w.protocol) && $urandom_range(0, 9) < 7) begin
         w.src_l4_port = '0;
         w.dst_l4_port = '0;
      end
      return w;
   endfunction

   function automatic req_word_type colliding_key(input int unsigned target,
                                                  input opcode_type op);
      req_word_type w;
      do
         w = random_key(op);
      while (flow_index(w) != target);
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int unsigned gap;
      if (!calm && $urandom_range(0, 99) < 16) begin
         gap = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do
         @(posedge clock);
      while (!req_chan.ready);
      expected_rsp_q.push_back(classify_word(w));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_item();
      req_word_type w;
      int unsigned pick;
      int unsigned sel;
      pick = $urandom_range(0, 99);
      if (rule_pool.size() == 0 || pick < 35) begin
         if (rule_pool.size() != 0 && $urandom_range(0, 9) == 0) begin
            sel = $urandom_range(0, rule_pool.size() - 1);
            w = colliding_key(flow_index(rule_pool[sel]), OP_INSERT);
         end else begin
            w = random_key(OP_INSERT);
         end
         rule_pool.push_back(w);
         if (rule_pool.size() > POOL_MAX)
            void'(rule_pool.pop_front());
      end else if (pick < 80) begin
         sel = $urandom_range(0, rule_pool.size() - 1);
         w = as_lookup(rule_pool[sel]);
         if (!has_ports(w.protocol)) begin
            w.src_l4_port = rand_port();
            w.dst_l4_port = rand_port();
         end
      end else if (pick < 90) begin
         // near miss: one bit of one key field flipped
         sel = $urandom_range(0, rule_pool.size() - 1);
         w = as_lookup(rule_pool[sel]);
         case ($urandom_range(0, 4))
            0: w.src_address[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
            1: w.dst_address[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
            2: w.src_l4_port[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
            3: w.dst_l4_port[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
            default: w.protocol[$urandom_range(0, PROTO_W - 1)] ^= 1'b1;
         endcase
      end else begin
         w = random_key(OP_LOOKUP);
      end
      send_word(w);
   endtask

   // ---------------- tests ----------------

   task automatic test_empty_table();
      send_word(make_word(OP_LOOKUP, '0, '0, '0, '0, 8'h00, 1'b0));
      send_word(make_word(OP_LOOKUP, '1, '1, '1, '1, 8'hFF, 1'b1));
      send_word(make_word(OP_LOOKUP, 32'h0A00_0001, 32'hC0A8_0101, 16'd1234, 16'd80,
                          PROTO_TCP, 1'b0));
   endtask

   task automatic test_directed_rules();
      req_word_type all_ones;
      req_word_type all_zero;
      req_word_type tcp_rule;
      req_word_type udp_rule;
      req_word_type icmp_rule;
      req_word_type clash;
      req_word_type k;
      // portless protocol with nonzero ports: stored as given, never matches
      all_ones = make_word(OP_INSERT, '1, '1, '1, '1, 8'hFF, 1'b0);
      send_word(all_ones);
      send_word(as_lookup(all_ones));
      all_zero = make_word(OP_INSERT, '0, '0, '0, '0, 8'h00, 1'b0);
      send_word(all_zero);
      send_word(as_lookup(all_zero));
      k = as_lookup(all_zero);
      k.src_l4_port = '1;
      k.dst_l4_port = '1;
      send_word(k);
      tcp_rule = make_word(OP_INSERT, 32'hC0A8_0A01, 32'h0A01_0203, 16'hFFFF, 16'd443,
                           PROTO_TCP, 1'b1);
      send_word(tcp_rule);
      send_word(as_lookup(tcp_rule));
      udp_rule = make_word(OP_INSERT, 32'h8000_0000, 32'h0000_0001, 16'd53, 16'h0000,
                           PROTO_UDP, 1'b0);
      send_word(udp_rule);
      send_word(as_lookup(udp_rule));
      k = as_lookup(udp_rule);
      k.dst_l4_port ^= 16'h8000;
      send_word(k);
      k = as_lookup(tcp_rule);
      k.protocol = PROTO_UDP;
      send_word(k);
      icmp_rule = make_word(OP_INSERT, 32'h7F00_0001, 32'hFFFF_FFFE, '0, '0, PROTO_ICMP, 1'b1);
      send_word(icmp_rule);
      k = as_lookup(icmp_rule);
      k.src_l4_port = 16'hA5A5;
      k.dst_l4_port = 16'h5A5A;
      send_word(k);
      // another rule landing in the same bucket replaces the first
      clash = colliding_key(flow_index(tcp_rule), OP_INSERT);
      clash.rule_action = 1'b0;
      send_word(clash);
      send_word(as_lookup(tcp_rule));
      send_word(as_lookup(clash));
      // same key again with the other action
      tcp_rule.rule_action = 1'b0;
      send_word(tcp_rule);
      send_word(as_lookup(tcp_rule));
      clash.rule_action = 1'b1;
      send_word(clash);
      send_word(as_lookup(clash));
   endtask

   task automatic test_random_calm(input int unsigned count);
      calm = 1'b1;
      repeat (count) random_item();
      calm = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (6) random_item();
      wait_for_results();
      repeat (6) random_item();
   endtask

   task automatic test_random_traffic(input int unsigned count);
      repeat (count) random_item();
   endtask

   initial begin
      foreach (rule_table[i])
         rule_table[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_rules();
      test_random_calm(300);
      test_pause_until_drained();
      test_random_traffic(1030);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
